/* rtl/mph_pkg.sv */
// Shared types, codes and the priority compare for the magnitude priority heap.
package mph_pkg;

  localparam int CAPACITY = 64;
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int VALUE_W = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
    logic [VALUE_W-1:0] value;
  } cell_op_t;

  typedef struct packed {
    logic valid;
    logic goes_above;
    logic [VALUE_W-1:0] value;
  } cell_link_t;

  function automatic logic [VALUE_W:0] magnitude(input logic [VALUE_W-1:0] x);
    logic [VALUE_W:0] ext;
    ext = {x[VALUE_W-1], x};
    return x[VALUE_W-1] ? (~ext + {{VALUE_W{1'b0}}, 1'b1}) : ext;
  endfunction

  function automatic logic outranks(input logic [VALUE_W-1:0] a,
                                    input logic [VALUE_W-1:0] b);
    logic [VALUE_W:0] ma;
    logic [VALUE_W:0] mb;
    ma = magnitude(a);
    mb = magnitude(b);
    if (ma != mb) begin
      return ma > mb;
    end
    return $signed(a) < $signed(b);
  endfunction

endpackage

/* rtl/mph_cell.sv */
// One cell of the sorted queue: holds one entry and shifts with its neighbors.
module mph_cell (
  input  logic                clk,
  input  logic                rst,
  input  mph_pkg::cell_op_t   op,
  input  mph_pkg::cell_link_t left,
  input  mph_pkg::cell_link_t right,
  output mph_pkg::cell_link_t self
);

  logic                        valid;
  logic [mph_pkg::VALUE_W-1:0] value;
  logic                        valid_next;
  logic [mph_pkg::VALUE_W-1:0] value_next;
  logic                        goes_above;

  assign goes_above = !valid || mph_pkg::outranks(op.value, value);

  assign self.valid = valid;
  assign self.value = value;
  assign self.goes_above = goes_above;

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (op.push) begin
      valid_next = valid | left.valid;
      if (goes_above) begin
        if (left.goes_above) begin
          value_next = left.value;
        end else begin
          value_next = op.value;
        end
      end
    end else if (op.pop) begin
      valid_next = right.valid;
      value_next = right.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

endmodule

/* rtl/magnitude_priority_heap.sv */
// Top level of the magnitude priority heap: handshake, count and the chain of cells.
//
// A bounded priority queue of signed 32-bit values. Each input transaction
// carries cmd and value_in: a push inserts value_in, a pop removes the entry
// of highest priority, which is the one of largest magnitude, the negative
// one winning on a tie. Every input transaction yields exactly one output
// transaction with value_out, status and entry_count after the operation.
// A pop on an empty queue reports the empty status and a push on a full
// queue is dropped with the full status; in both cases nothing changes.
// The entries sit in a row of cells kept in priority order, so the result
// of each operation appears in the cycle after acceptance and one
// transaction can be accepted every cycle while in_stall is low.
// The output register holds a result until it is taken; in_stall is high
// only while that register is full and out_stall is high.
// A synchronous reset empties the queue and drops any pending result.
module magnitude_priority_heap (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic signed [mph_pkg::VALUE_W-1:0] value_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mph_pkg::VALUE_W-1:0] value_out,
  output logic [1:0]                         status,
  output logic [mph_pkg::COUNT_W-1:0]        entry_count
);

  mph_pkg::cell_op_t   op;
  mph_pkg::cell_link_t links [mph_pkg::CAPACITY];
  mph_pkg::cell_link_t head_link;
  mph_pkg::cell_link_t tail_link;

  logic                        accept;
  logic                        full;
  logic                        empty;
  logic [mph_pkg::COUNT_W-1:0] count;
  logic [mph_pkg::COUNT_W-1:0] count_next;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;
  assign full = count >= mph_pkg::COUNT_W'(mph_pkg::CAPACITY);
  assign empty = count == '0;

  assign op.push = accept && (cmd == mph_pkg::CMD_PUSH) && !full;
  assign op.pop = accept && (cmd == mph_pkg::CMD_POP) && !empty;
  assign op.value = value_in;

  assign head_link.valid = 1'b1;
  assign head_link.goes_above = 1'b0;
  assign head_link.value = '0;
  assign tail_link.valid = 1'b0;
  assign tail_link.goes_above = 1'b0;
  assign tail_link.value = '0;

  for (genvar i = 0; i < mph_pkg::CAPACITY; i++) begin : g_cell
    mph_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .left  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
      .right ((i == mph_pkg::CAPACITY - 1) ? tail_link
                : links[(i == mph_pkg::CAPACITY - 1) ? i : i + 1]),
      .self  (links[i])
    );
  end

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + 1'b1;
    end else if (op.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      entry_count <= count_next;
      value_out <= op.pop ? links[0].value : '0;
      if ((cmd == mph_pkg::CMD_POP) && empty) begin
        status <= mph_pkg::STATUS_EMPTY;
      end else if ((cmd == mph_pkg::CMD_PUSH) && full) begin
        status <= mph_pkg::STATUS_FULL;
      end else begin
        status <= mph_pkg::STATUS_OK;
      end
    end
  end

endmodule
